/* src/tfd_pkg.sv */
// ============================================================================
// tfd_pkg: tone frame decode and synthesis shared definitions
// widths, codes, tone tables and elaboration-time helpers
// ============================================================================
package tfd_pkg;

    localparam int COS_TABLE_DEPTH_DEF = 1024;
    localparam int PHASE_BITS_DEF      = 32;

    localparam int FRAME_LOW_W  = 52;
    localparam int FRAME_HIGH_W = 51;
    localparam int FRAME_W      = FRAME_LOW_W + FRAME_HIGH_W;
    localparam int SAMPLE_W     = 16;
    localparam int GAIN_W       = 15;
    localparam int LAMP_W       = 8;
    localparam int CODE_W       = 8;
    localparam int CODES        = 2 ** CODE_W;
    localparam int LAMPS        = 2 ** LAMP_W;
    localparam int COS_MAG_W    = 31;
    localparam int COS_W        = COS_MAG_W + 1;
    localparam int Q_SHIFT      = 30;

    // majority vote layout
    localparam int VOTE_COPIES = 10;
    localparam int VOTE_MIN    = 5;
    localparam int VOTE_BASE   = 20;
    localparam int VOTE_STRIDE = 8;

    // log amplitude bit positions, msb first
    localparam int AMP_POS [LAMP_W] = '{10, 11, 12, 15, 16, 17, 18, 19};

    localparam int GAIN_STEPS = 17;
    localparam int SINGLE_MUL = 125;

    localparam logic [63:0] SAMPLE_RATE = 64'd8000;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;

    // frequency code ranges
    localparam logic [CODE_W-1:0] CODE_DTMF_END  = 8'h10;
    localparam logic [CODE_W-1:0] CODE_SINGLE_LO = 8'h15;
    localparam logic [CODE_W-1:0] CODE_SINGLE_HI = 8'h8a;
    localparam logic [CODE_W-1:0] CODE_CALL_LO   = 8'h90;
    localparam logic [CODE_W-1:0] CODE_CALL_END  = 8'h94;

    typedef enum logic [1:0] {
        KIND_SILENT = 2'd0,
        KIND_DTMF   = 2'd1,
        KIND_SINGLE = 2'd2,
        KIND_CALL   = 2'd3
    } t_kind;

    typedef enum logic {
        REQ_LOAD   = 1'b0,
        REQ_SAMPLE = 1'b1
    } t_req;

    typedef struct packed {
        t_kind             kind;
        logic              invalid;
        logic [GAIN_W-1:0] gain;
    } t_dec;

    typedef struct packed {
        logic              en_one;
        logic              en_two;
        logic [GAIN_W-1:0] gain;
    } t_mix_ctl;

    localparam logic [GAIN_W-1:0] AMP_TAB [GAIN_STEPS] = '{
        15'd32767, 15'd31458, 15'd30201, 15'd28994, 15'd27836, 15'd26724,
        15'd25656, 15'd24631, 15'd23647, 15'd22702, 15'd21795, 15'd20924,
        15'd20088, 15'd19286, 15'd18515, 15'd17776, 15'd17065
    };

    localparam logic [10:0] DTMF_HI [16] = '{
        11'd1336, 11'd1209, 11'd1336, 11'd1477, 11'd1209, 11'd1336, 11'd1477, 11'd1209,
        11'd1336, 11'd1477, 11'd1633, 11'd1633, 11'd1633, 11'd1633, 11'd1477, 11'd1209
    };
    localparam logic [10:0] DTMF_LO [16] = '{
        11'd941, 11'd697, 11'd697, 11'd697, 11'd770, 11'd770, 11'd770, 11'd852,
        11'd852, 11'd852, 11'd697, 11'd770, 11'd852, 11'd941, 11'd941, 11'd941
    };
    localparam logic [10:0] CP_ONE [4] = '{11'd440, 11'd480, 11'd630, 11'd490};
    localparam logic [10:0] CP_TWO [4] = '{11'd350, 11'd440, 11'd480, 11'd350};

    // phase increment for a tone, rounded
    function automatic logic [63:0] step_for(input int hz, input int pbits);
        logic [63:0] num;
        num = (64'(hz) << pbits) + SAMPLE_RATE / 2;
        return num / SAMPLE_RATE;
    endfunction

    typedef logic [LAMPS-1:0][GAIN_W-1:0] t_gain_tab;

    // gain from log amplitude: amp[d mod 17] >> (d / 17), d = 255 - lamp
    function automatic t_gain_tab build_gain_tab();
        t_gain_tab tab;
        int        d;
        for (int l = 0; l < LAMPS; l++) begin
            d      = LAMPS - 1 - l;
            tab[l] = GAIN_W'(AMP_TAB[d % GAIN_STEPS] >> (d / GAIN_STEPS));
        end
        return tab;
    endfunction

    localparam t_gain_tab GAIN_TAB = build_gain_tab();

endpackage

/* src/tfd_req_if.sv */
// ============================================================================
// tfd_req_if: request channel
// valid/ready channel carrying one frame-load or sample request word
// ============================================================================
interface tfd_req_if;
    import tfd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic [FRAME_LOW_W-1:0]  frame_low;
    logic [FRAME_HIGH_W-1:0] frame_high;
    logic                    last_of_frame;

    modport source (
        output valid, req_type, frame_low, frame_high, last_of_frame,
        input  ready
    );
    modport sink (
        input  valid, req_type, frame_low, frame_high, last_of_frame,
        output ready
    );
endinterface

/* src/tfd_smp_if.sv */
// ============================================================================
// tfd_smp_if: result channel
// valid/ready channel carrying one audio sample or frame-load status word
// ============================================================================
interface tfd_smp_if;
    import tfd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       status;
    t_kind                      tone_kind;
    logic                       last;

    modport source (
        output valid, sample, status, tone_kind, last,
        input  ready
    );
    modport sink (
        input  valid, sample, status, tone_kind, last,
        output ready
    );
endinterface

/* src/tfd_decode.sv */
// ============================================================================
// tfd_decode: tone frame decoder
// log amplitude gather, majority-voted code, tone kind, gain and phase steps
// ============================================================================
module tfd_decode #(
    parameter int PHASE_BITS = tfd_pkg::PHASE_BITS_DEF
) (
    input  logic [tfd_pkg::FRAME_LOW_W-1:0]  i_frame_low,
    input  logic [tfd_pkg::FRAME_HIGH_W-1:0] i_frame_high,
    output tfd_pkg::t_dec                    o_dec,
    output logic [PHASE_BITS-1:0]            o_step_one,
    output logic [PHASE_BITS-1:0]            o_step_two
);
    import tfd_pkg::*;

    typedef logic [CODES-1:0][PHASE_BITS-1:0] t_step_tab;

    // per-code step of the first or second oscillator
    function automatic t_step_tab build_step_tab(input logic second);
        t_step_tab tab;
        int        hz;
        for (int c = 0; c < CODES; c++) begin
            hz = 0;
            if (c < int'(CODE_DTMF_END)) begin
                hz = second ? int'(DTMF_LO[c]) : int'(DTMF_HI[c]);
            end else if (c >= int'(CODE_SINGLE_LO) && c <= int'(CODE_SINGLE_HI)) begin
                hz = second ? 0 : ((c - int'(CODE_DTMF_END)) * SINGLE_MUL) / 4;
            end else if (c >= int'(CODE_CALL_LO) && c < int'(CODE_CALL_END)) begin
                hz = second ? int'(CP_TWO[c % 4]) : int'(CP_ONE[c % 4]);
            end
            tab[c] = PHASE_BITS'(step_for(hz, PHASE_BITS));
        end
        return tab;
    endfunction

    localparam t_step_tab STEP_ONE_TAB = build_step_tab(1'b0);
    localparam t_step_tab STEP_TWO_TAB = build_step_tab(1'b1);

    logic [FRAME_W-1:0]     frame;
    logic [LAMP_W-1:0]      lamp;
    logic [CODE_W-1:0]      code;
    logic [VOTE_COPIES-1:0] copies [CODE_W];

    assign frame = {i_frame_high, i_frame_low};

    always_comb begin
        for (int i = 0; i < LAMP_W; i++) begin
            lamp[LAMP_W-1-i] = frame[AMP_POS[i]];
        end
        for (int i = 0; i < CODE_W; i++) begin
            for (int j = 0; j < VOTE_COPIES; j++) begin
                copies[i][j] = frame[VOTE_BASE + VOTE_STRIDE * j + i];
            end
            code[CODE_W-1-i] = ($countones(copies[i]) >= VOTE_MIN);
        end
    end

    always_comb begin
        o_dec.gain    = GAIN_TAB[lamp];
        o_dec.invalid = 1'b0;
        if (code < CODE_DTMF_END) begin
            o_dec.kind = KIND_DTMF;
        end else if (code >= CODE_SINGLE_LO && code <= CODE_SINGLE_HI) begin
            o_dec.kind = KIND_SINGLE;
        end else if (code >= CODE_CALL_LO && code < CODE_CALL_END) begin
            o_dec.kind = KIND_CALL;
        end else begin
            o_dec.kind    = KIND_SILENT;
            o_dec.invalid = 1'b1;
        end
    end

    assign o_step_one = STEP_ONE_TAB[code];
    assign o_step_two = STEP_TWO_TAB[code];

endmodule

/* src/tfd_cos_rom.sv */
// ============================================================================
// tfd_cos_rom: cosine table
// dual-read synchronous rom of sign and q30 magnitude per phase index
// ============================================================================
module tfd_cos_rom #(
    parameter int DEPTH = tfd_pkg::COS_TABLE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [$clog2(DEPTH)-1:0]    i_addr_one,
    input  logic [$clog2(DEPTH)-1:0]    i_addr_two,
    output logic [tfd_pkg::COS_W-1:0]   o_word_one,
    output logic [tfd_pkg::COS_W-1:0]   o_word_two
);
    import tfd_pkg::*;

    typedef logic [DEPTH-1:0][COS_W-1:0] t_rom;

    // folded angle, horner series through x^10, clamped at zero
    function automatic logic [COS_W-1:0] cos_entry(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] inner;
        logic [63:0] t;
        logic        neg;
        x   = (64'(k) * TWO_PI_Q30) / 64'(DEPTH);
        neg = 1'b0;
        if (x > PI_Q30) begin
            x = (x >= TWO_PI_Q30) ? 64'd0 : (TWO_PI_Q30 - x);
        end
        if (x > HALF_PI_Q30) begin
            neg = 1'b1;
            x   = (x >= PI_Q30) ? 64'd0 : (PI_Q30 - x);
        end
        x2    = (x * x) >> Q_SHIFT;
        inner = ONE_Q30;
        t     = ((x2 * inner) >> Q_SHIFT) / 64'd90;
        inner = (t >= ONE_Q30) ? 64'd0 : (ONE_Q30 - t);
        t     = ((x2 * inner) >> Q_SHIFT) / 64'd56;
        inner = (t >= ONE_Q30) ? 64'd0 : (ONE_Q30 - t);
        t     = ((x2 * inner) >> Q_SHIFT) / 64'd30;
        inner = (t >= ONE_Q30) ? 64'd0 : (ONE_Q30 - t);
        t     = ((x2 * inner) >> Q_SHIFT) / 64'd12;
        inner = (t >= ONE_Q30) ? 64'd0 : (ONE_Q30 - t);
        t     = ((x2 * inner) >> Q_SHIFT) / 64'd2;
        inner = (t >= ONE_Q30) ? 64'd0 : (ONE_Q30 - t);
        return {neg, inner[COS_MAG_W-1:0]};
    endfunction

    function automatic t_rom build_rom();
        t_rom rom;
        for (int k = 0; k < DEPTH; k++) begin
            rom[k] = cos_entry(k);
        end
        return rom;
    endfunction

    localparam t_rom COS_ROM = build_rom();

    logic [COS_W-1:0] r_word_one;
    logic [COS_W-1:0] r_word_two;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word_one <= COS_ROM[i_addr_one];
            r_word_two <= COS_ROM[i_addr_two];
        end
    end

    assign o_word_one = r_word_one;
    assign o_word_two = r_word_two;

endmodule

/* src/tfd_mix.sv */
// ============================================================================
// tfd_mix: tone mixer
// scales both cosine words by the gain, applies signs and sums the tones
// ============================================================================
module tfd_mix (
    input  tfd_pkg::t_mix_ctl                  i_ctl,
    input  logic [tfd_pkg::COS_W-1:0]          i_word_one,
    input  logic [tfd_pkg::COS_W-1:0]          i_word_two,
    output logic signed [tfd_pkg::SAMPLE_W-1:0] o_sample
);
    import tfd_pkg::*;

    localparam int PROD_W = GAIN_W + COS_MAG_W;

    logic [PROD_W-1:0]          prod_one;
    logic [PROD_W-1:0]          prod_two;
    logic [GAIN_W-1:0]          mag_one;
    logic [GAIN_W-1:0]          mag_two;
    logic signed [SAMPLE_W:0]   term_one;
    logic signed [SAMPLE_W:0]   term_two;
    logic signed [SAMPLE_W:0]   sum;

    assign prod_one = PROD_W'(i_ctl.gain) * PROD_W'(i_word_one[COS_MAG_W-1:0]);
    assign prod_two = PROD_W'(i_ctl.gain) * PROD_W'(i_word_two[COS_MAG_W-1:0]);

    // magnitude never exceeds the gain
    assign mag_one = prod_one[Q_SHIFT +: GAIN_W];
    assign mag_two = prod_two[Q_SHIFT +: GAIN_W];

    always_comb begin
        term_one = '0;
        term_two = '0;
        if (i_ctl.en_one) begin
            term_one = i_word_one[COS_W-1] ? -$signed({2'b00, mag_one})
                                           :  $signed({2'b00, mag_one});
        end
        if (i_ctl.en_two) begin
            term_two = i_word_two[COS_W-1] ? -$signed({2'b00, mag_two})
                                           :  $signed({2'b00, mag_two});
        end
        sum = term_one + term_two;
    end

    assign o_sample = sum[SAMPLE_W-1:0];

endmodule

/* src/tone_frame_decode_synth.sv */
// ============================================================================
// tone_frame_decode_synth: tone frame decoder and two-tone synthesizer
// path: an accepted request word passes stage a, stage b and the result register
// throughput: one word per cycle unless the result channel stalls, set by the dual-read cosine rom
// reset: synchronous active low; clears pipeline valids, phases, steps,
// gain and active kind (silent); no clearing pass, ready right after reset
// ============================================================================
module tone_frame_decode_synth #(
    parameter int COS_TABLE_DEPTH = tfd_pkg::COS_TABLE_DEPTH_DEF,
    parameter int PHASE_BITS      = tfd_pkg::PHASE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tfd_req_if.sink       i_req,
    tfd_smp_if.source     o_smp
);
    import tfd_pkg::*;

    localparam int AW     = $clog2(COS_TABLE_DEPTH);
    localparam int IDX_W  = PHASE_BITS + AW + 1;

    // ------------------------------------------------------------------
    // pipeline flow: each stage moves on when empty or the next one moves
    // ------------------------------------------------------------------
    logic adv_out;
    logic adv_b;
    logic adv_a;
    logic a_fire;

    // stage a: input register
    logic                    r_a_valid;
    logic                    r_a_req;
    logic [FRAME_LOW_W-1:0]  r_a_low;
    logic [FRAME_HIGH_W-1:0] r_a_high;
    logic                    r_a_last;

    // oscillator state
    logic [PHASE_BITS-1:0]   r_phase_one;
    logic [PHASE_BITS-1:0]   r_phase_two;
    logic [PHASE_BITS-1:0]   r_step_one;
    logic [PHASE_BITS-1:0]   r_step_two;
    logic [GAIN_W-1:0]       r_gain;
    t_kind                   r_kind;

    // stage b: rom data and control
    logic                    r_b_valid;
    t_mix_ctl                r_b_ctl;
    logic                    r_b_status;
    t_kind                   r_b_kind;
    logic                    r_b_last;

    // result register
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_out_status;
    t_kind                      r_out_kind;
    logic                       r_out_last;

    assign adv_out = !r_out_valid || o_smp.ready;
    assign adv_b   = !r_b_valid || adv_out;
    assign adv_a   = !r_a_valid || adv_b;
    assign a_fire  = r_a_valid && adv_b;

    assign i_req.ready = adv_a;

    // ------------------------------------------------------------------
    // stage a capture
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv_a) begin
            r_a_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a && i_req.valid) begin
            r_a_req  <= i_req.req_type;
            r_a_low  <= i_req.frame_low;
            r_a_high <= i_req.frame_high;
            r_a_last <= i_req.last_of_frame;
        end
    end

    // ------------------------------------------------------------------
    // frame decode, used only by frame-load words
    // ------------------------------------------------------------------
    t_dec                  dec;
    logic [PHASE_BITS-1:0] dec_step_one;
    logic [PHASE_BITS-1:0] dec_step_two;

    tfd_decode #(
        .PHASE_BITS (PHASE_BITS)
    ) u_decode (
        .i_frame_low  (r_a_low),
        .i_frame_high (r_a_high),
        .o_dec        (dec),
        .o_step_one   (dec_step_one),
        .o_step_two   (dec_step_two)
    );

    // ------------------------------------------------------------------
    // stage a control for the word headed to stage b
    // ------------------------------------------------------------------
    t_mix_ctl a_ctl;
    logic     a_status;
    t_kind    a_kind;
    logic     a_last;
    logic     a_pair;

    assign a_pair = (r_kind == KIND_DTMF) || (r_kind == KIND_CALL);

    always_comb begin
        a_ctl.en_one = 1'b0;
        a_ctl.en_two = 1'b0;
        a_ctl.gain   = '0;
        a_status     = 1'b0;
        a_kind       = r_kind;
        a_last       = 1'b0;
        if (r_a_req == REQ_SAMPLE) begin
            a_last       = r_a_last;
            a_ctl.en_one = (r_kind != KIND_SILENT);
            a_ctl.en_two = a_pair;
            // pairs split the gain between the two tones
            a_ctl.gain   = a_pair ? (r_gain >> 1) : r_gain;
        end else begin
            a_status = dec.invalid;
            a_kind   = dec.kind;
        end
    end

    // ------------------------------------------------------------------
    // oscillator state: frame loads set steps, samples advance phases
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_one <= '0;
            r_phase_two <= '0;
            r_step_one  <= '0;
            r_step_two  <= '0;
            r_gain      <= '0;
            r_kind      <= KIND_SILENT;
        end else if (a_fire) begin
            if (r_a_req == REQ_SAMPLE) begin
                if (r_kind != KIND_SILENT) begin
                    r_phase_one <= r_phase_one + r_step_one;
                end
                if (a_pair) begin
                    r_phase_two <= r_phase_two + r_step_two;
                end
            end else begin
                // invalid code goes silent, steps and gain are kept
                r_kind <= dec.kind;
                if (!dec.invalid) begin
                    r_step_one <= dec_step_one;
                    r_gain     <= dec.gain;
                end
                if (dec.kind == KIND_DTMF || dec.kind == KIND_CALL) begin
                    r_step_two <= dec_step_two;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // phase to table index and cosine lookup for both tones
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]  idx_one;
    logic [IDX_W-1:0]  idx_two;
    logic [AW-1:0]     addr_one;
    logic [AW-1:0]     addr_two;
    logic [COS_W-1:0]  cos_one;
    logic [COS_W-1:0]  cos_two;

    assign idx_one  = IDX_W'(r_phase_one) * IDX_W'(COS_TABLE_DEPTH);
    assign idx_two  = IDX_W'(r_phase_two) * IDX_W'(COS_TABLE_DEPTH);
    assign addr_one = idx_one[PHASE_BITS +: AW];
    assign addr_two = idx_two[PHASE_BITS +: AW];

    tfd_cos_rom #(
        .DEPTH (COS_TABLE_DEPTH)
    ) u_cos_rom (
        .i_clk      (i_clk),
        .i_en       (adv_b),
        .i_addr_one (addr_one),
        .i_addr_two (addr_two),
        .o_word_one (cos_one),
        .o_word_two (cos_two)
    );

    // ------------------------------------------------------------------
    // stage b capture, alongside the rom read register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_b_ctl    <= a_ctl;
            r_b_status <= a_status;
            r_b_kind   <= a_kind;
            r_b_last   <= a_last;
        end
    end

    // ------------------------------------------------------------------
    // mixer and result register
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] mix_sample;

    tfd_mix u_mix (
        .i_ctl      (r_b_ctl),
        .i_word_one (cos_one),
        .i_word_two (cos_two),
        .o_sample   (mix_sample)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_b_valid) begin
            r_out_sample <= mix_sample;
            r_out_status <= r_b_status;
            r_out_kind   <= r_b_kind;
            r_out_last   <= r_b_last;
        end
    end

    assign o_smp.valid     = r_out_valid;
    assign o_smp.sample    = r_out_sample;
    assign o_smp.status    = r_out_status;
    assign o_smp.tone_kind = r_out_kind;
    assign o_smp.last      = r_out_last;

`ifndef SYNTHESIS
    // a single tone never moves the second oscillator
    a_single_phase_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_fire && r_a_req == REQ_SAMPLE && r_kind == KIND_SINGLE)
        |=> $stable(r_phase_two))
        else $error("second phase moved during a single tone");

    // phases only move when a word leaves stage a
    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !a_fire |=> ($stable(r_phase_one) && $stable(r_phase_two)))
        else $error("phase changed without a word in flight");

    // silent words reach the mixer with both tones off
    a_silent_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_kind == KIND_SILENT) |-> (!r_b_ctl.en_one && !r_b_ctl.en_two))
        else $error("tone enabled for a silent word");

    // an invalid code always reports silence
    a_invalid_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status) |-> (r_out_kind == KIND_SILENT))
        else $error("invalid code with a non-silent kind");
`endif

endmodule

/* verif/tone_frame_decode_synth_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tone_frame_decode_synth_tb: self-checking bench for the tone synthesizer
// Drives frame-load and sample request words through the request channel and
// predicts every result word: the majority-voted frequency code, the log
// amplitude gain, both phase accumulators and the truncated cosine terms.
// Each result word is compared field by field against the oldest prediction.
// ============================================================================
module tone_frame_decode_synth_tb;
    import tfd_pkg::*;

    localparam int          PH_W           = 32;
    localparam logic [63:0] COS_N          = 64'd1024;
    localparam logic [63:0] SAMPLE_HZ      = 64'd8000;
    localparam logic [63:0] Q30_ONE        = 64'd1073741824;
    localparam logic [63:0] Q30_HALF_PI    = 64'd1686629713;
    localparam logic [63:0] Q30_PI         = 64'd3373259426;
    localparam logic [63:0] Q30_TWO_PI     = 64'd6746518852;
    localparam logic [63:0] TAYLOR_DIV [5] = '{64'd90, 64'd56, 64'd30, 64'd12, 64'd2};

    // frequency code map
    localparam logic [7:0] C_DTMF_END  = 8'h10;
    localparam logic [7:0] C_SINGLE_LO = 8'h15;
    localparam logic [7:0] C_SINGLE_HI = 8'h8a;
    localparam logic [7:0] C_CALL_LO   = 8'h90;
    localparam logic [7:0] C_CALL_HI   = 8'h93;
    localparam logic [7:0] C_CALL_END  = 8'h94;
    localparam int         SINGLE_MULT = 125;
    localparam int         LAMP_STEPS  = 17;

    localparam int AMP_STEPS [17] = '{
        32767, 31458, 30201, 28994, 27836, 26724, 25656, 24631, 23647,
        22702, 21795, 20924, 20088, 19286, 18515, 17776, 17065
    };
    localparam int DTMF_COL_HZ [16] = '{
        1336, 1209, 1336, 1477, 1209, 1336, 1477, 1209,
        1336, 1477, 1633, 1633, 1633, 1633, 1477, 1209
    };
    localparam int DTMF_ROW_HZ [16] = '{
        941, 697, 697, 697, 770, 770, 770, 852,
        852, 852, 697, 770, 852, 941, 941, 941
    };
    localparam int CP_A_HZ [4] = '{440, 480, 630, 490};
    localparam int CP_B_HZ [4] = '{350, 440, 480, 350};

    localparam int ITEMS_TOTAL    = 1650;
    localparam int HOLD_LEN       = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;

    typedef struct packed {
        logic [15:0] sample;
        logic        status;
        t_kind       kind;
        logic        last;
    } t_smp_word;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tfd_req_if req_ch ();
    tfd_smp_if smp_ch ();

    tone_frame_decode_synth uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_smp   (smp_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted synthesizer state
    logic [31:0] ph_one, ph_two, inc_one, inc_two;
    logic [14:0] gain_now;
    t_kind       kind_now;

    t_smp_word pending_words [$];
    int        mismatches   = 0;
    int        words_sent   = 0;
    int        stuck_cycles = 0;

    // quiet: no random idling on either side
    logic quiet     = 1'b0;
    // stall_req toggles to ask the receiver for one long hold-off
    logic stall_req = 1'b0;
    logic stall_ack = 1'b0;
    int   stall_left = 0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // rounded phase increment at 8 kHz
    function automatic logic [31:0] tone_inc(int hz);
        return 32'(((64'(hz) << PH_W) + SAMPLE_HZ / 2) / SAMPLE_HZ);
    endfunction

    // q30 cosine magnitude on [0, pi/2], horner series, clamped at zero
    function automatic logic [63:0] cos_mag(logic [63:0] x);
        logic [63:0] x2, acc, t;
        x2  = (x * x) >> 30;
        acc = Q30_ONE;
        for (int i = 0; i < 5; i++) begin
            t   = ((x2 * acc) >> 30) / TAYLOR_DIV[i];
            acc = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
        end
        return acc;
    endfunction

    // one tone term, truncated toward zero
    function automatic int tone_val(logic [14:0] g, logic [31:0] ph);
        logic [63:0] k, x, mag;
        logic        neg;
        k   = (64'(ph) * COS_N) >> PH_W;
        x   = (k * Q30_TWO_PI) / COS_N;
        neg = 1'b0;
        if (x > Q30_PI)
            x = (x >= Q30_TWO_PI) ? 64'd0 : Q30_TWO_PI - x;
        if (x > Q30_HALF_PI) begin
            neg = 1'b1;
            x   = (x >= Q30_PI) ? 64'd0 : Q30_PI - x;
        end
        mag = (64'(g) * cos_mag(x)) >> 30;
        return neg ? -int'(mag) : int'(mag);
    endfunction

    // advance the predicted state by one request word and return its result
    function automatic t_smp_word synth_word(t_req rt, logic [FRAME_W-1:0] fr, logic lof);
        t_smp_word   w;
        logic [7:0]  lamp, code;
        logic [14:0] g, half;
        int          d, ones, s;
        w.sample = '0;
        w.status = 1'b0;
        w.last   = 1'b0;
        s        = 0;
        if (rt == REQ_LOAD) begin
            lamp = {fr[10], fr[11], fr[12], fr[15], fr[16], fr[17], fr[18], fr[19]};
            // code bit 7-i is the majority of ten copies spaced a byte apart
            for (int i = 0; i < 8; i++) begin
                ones = 0;
                for (int j = 0; j < 10; j++)
                    ones += fr[20 + 8 * j + i];
                code[7 - i] = (ones >= 5);
            end
            d = 255 - int'(lamp);
            g = 15'(AMP_STEPS[d % LAMP_STEPS] >> (d / LAMP_STEPS));
            if (code < C_DTMF_END) begin
                inc_one  = tone_inc(DTMF_COL_HZ[code[3:0]]);
                inc_two  = tone_inc(DTMF_ROW_HZ[code[3:0]]);
                gain_now = g;
                kind_now = KIND_DTMF;
            end else if (code >= C_SINGLE_LO && code <= C_SINGLE_HI) begin
                inc_one  = tone_inc(((int'(code) - int'(C_DTMF_END)) * SINGLE_MULT) >> 2);
                gain_now = g;
                kind_now = KIND_SINGLE;
            end else if (code >= C_CALL_LO && code <= C_CALL_HI) begin
                inc_one  = tone_inc(CP_A_HZ[code[1:0]]);
                inc_two  = tone_inc(CP_B_HZ[code[1:0]]);
                gain_now = g;
                kind_now = KIND_CALL;
            end else begin
                // bad code: go silent, keep steps, phases and gain
                w.status = 1'b1;
                kind_now = KIND_SILENT;
            end
        end else begin
            w.last = lof;
            if (kind_now == KIND_SINGLE) begin
                s      = tone_val(gain_now, ph_one);
                ph_one = ph_one + inc_one;
            end else if (kind_now != KIND_SILENT) begin
                half   = gain_now >> 1;
                s      = tone_val(half, ph_one) + tone_val(half, ph_two);
                ph_one = ph_one + inc_one;
                ph_two = ph_two + inc_two;
            end
            w.sample = 16'(s);
        end
        w.kind = kind_now;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [FRAME_W-1:0] rand_frame();
        return FRAME_W'({$urandom, $urandom, $urandom, $urandom});
    endfunction

    // well-formed frame: amplitude bits set, each code bit carried by a vote
    // of ten copies; tight puts each vote right at the threshold
    function automatic logic [FRAME_W-1:0] make_frame(logic [7:0] code, logic [7:0] lamp,
                                                      logic tight);
        logic [FRAME_W-1:0] f;
        logic [9:0]         copies;
        int                 want, have, p;
        f = rand_frame();
        {f[10], f[11], f[12], f[15], f[16], f[17], f[18], f[19]} = lamp;
        for (int i = 0; i < 8; i++) begin
            if (tight)
                want = code[7 - i] ? 5 : 4;
            else
                want = code[7 - i] ? $urandom_range(10, 5) : $urandom_range(4, 0);
            copies = '0;
            have   = 0;
            while (have < want) begin
                p = $urandom_range(9);
                if (!copies[p]) begin
                    copies[p] = 1'b1;
                    have++;
                end
            end
            for (int j = 0; j < 10; j++)
                f[20 + 8 * j + i] = copies[j];
        end
        return f;
    endfunction

    function automatic logic [7:0] pick_code();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return 8'($urandom_range(int'(C_DTMF_END) - 1, 0));
        if (r < 65)
            return 8'($urandom_range(C_SINGLE_HI, C_SINGLE_LO));
        if (r < 80)
            return 8'($urandom_range(C_CALL_HI, C_CALL_LO));
        case ($urandom_range(2))
            0:       return 8'($urandom_range(int'(C_SINGLE_LO) - 1, C_DTMF_END));
            1:       return 8'($urandom_range(int'(C_CALL_LO) - 1, int'(C_SINGLE_HI) + 1));
            default: return 8'($urandom_range(255, C_CALL_END));
        endcase
    endfunction

    function automatic logic [7:0] pick_lamp();
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? 8'hff : 8'h00;
        return 8'($urandom_range(255));
    endfunction

    // offer one word, wait for the handshake, then record its prediction
    task automatic send_word(input t_req rt, input logic [FRAME_W-1:0] fr, input logic lof);
        while (!quiet && $urandom_range(99) < 25) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= rt;
        req_ch.frame_low     <= fr[FRAME_LOW_W-1:0];
        req_ch.frame_high    <= fr[FRAME_W-1:FRAME_LOW_W];
        req_ch.last_of_frame <= lof;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_words.push_back(synth_word(rt, fr, lof));
        words_sent++;
    endtask

    task automatic send_load(input logic [7:0] code, input logic [7:0] lamp, input logic tight);
        send_word(REQ_LOAD, make_frame(code, lamp, tight), 1'($urandom_range(1)));
    endtask

    // sample requests carry random frame bits, which must be ignored
    task automatic send_sample(input logic lof);
        send_word(REQ_SAMPLE, rand_frame(), lof);
    endtask

    // sender goes quiet until every predicted word has come back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_words.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // straight out of reset the synthesizer is silent
    task automatic test_silent_start();
        send_sample(1'b0);
        send_sample(1'b1);
    endtask

    // edges of every code range, the bad codes among them, each followed
    // by a sample so that silence after a bad code is seen too
    task automatic test_code_ranges();
        logic [7:0] codes [11];
        codes = '{8'h00, 8'h0f, C_SINGLE_LO, C_SINGLE_HI, C_CALL_LO, C_CALL_HI,
                  C_DTMF_END, 8'h14, 8'h8b, C_CALL_END, 8'hff};
        for (int i = 0; i < 11; i++) begin
            send_load(codes[i], 8'($urandom_range(255, 128)), 1'b0);
            send_sample(1'($urandom_range(1)));
        end
    endtask

    // votes exactly at five and four ones, full scale and zero amplitude
    task automatic test_vote_threshold();
        send_load(8'h5a, 8'hff, 1'b1);
        send_sample(1'b1);
        send_load(8'h0a, 8'h00, 1'b1);
        send_sample(1'b0);
    endtask

    // receiver holds off while the sender keeps pushing samples
    task automatic test_receiver_stall();
        send_load(8'h05, 8'hc8, 1'b0);
        stall_req <= ~stall_req;
        quiet     <= 1'b1;
        for (int n = 0; n < 48; n++)
            send_sample(n == 47);
        quiet <= 1'b0;
    endtask

    // sender stops mid-tone until the pipe is empty, then resumes
    task automatic test_sender_pause();
        send_load(8'h91, 8'he0, 1'b0);
        for (int n = 0; n < 6; n++)
            send_sample(1'b0);
        wait_drained();
        for (int n = 0; n < 6; n++)
            send_sample(n == 5);
    endtask

    // mostly well-formed frames with sample bursts, some noise frames and
    // bursts that keep the old tone; one long window without idling
    task automatic test_random_stream();
        int r, burst;
        while (words_sent < ITEMS_TOTAL) begin
            quiet <= (words_sent >= 900 && words_sent < 1200);
            r = $urandom_range(99);
            if (r < 80)
                send_load(pick_code(), pick_lamp(), 1'b0);
            else if (r < 90)
                send_word(REQ_LOAD, rand_frame(), 1'($urandom_range(1)));
            burst = $urandom_range(24, 1);
            for (int n = 0; n < burst; n++)
                send_sample((n == burst - 1) || ($urandom_range(9) == 0));
        end
        quiet <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result side: ready pattern and checking
    // ------------------------------------------------------------------

    task automatic check_word();
        t_smp_word got, want;
        got.sample = smp_ch.sample;
        got.status = smp_ch.status;
        got.kind   = smp_ch.tone_kind;
        got.last   = smp_ch.last;
        if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected word: sample %0d status %0b kind %0d last %0b",
                         $signed(got.sample), got.status, got.kind, got.last);
        end else begin
            want = pending_words.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: sample %0d/%0d status %0b/%0b kind %0d/%0d last %0b/%0b",
                             $signed(want.sample), $signed(got.sample), want.status,
                             got.status, want.kind, got.kind, want.last, got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_ch.ready <= 1'b0;
            stall_ack    <= stall_req;
            stall_left   <= 0;
        end else begin
            if (smp_ch.valid && smp_ch.ready)
                check_word();
            // a new hold-off request starts a counted stretch of ready low
            if (stall_req != stall_ack) begin
                stall_ack    <= stall_req;
                stall_left   <= HOLD_LEN;
                smp_ch.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left   <= stall_left - 1;
                smp_ch.ready <= 1'b0;
            end else begin
                smp_ch.ready <= quiet || ($urandom_range(99) >= 25);
            end
        end
    end

    // watchdog: too long without any word moving on either channel
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (smp_ch.valid && smp_ch.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        ph_one   = '0;
        ph_two   = '0;
        inc_one  = '0;
        inc_two  = '0;
        gain_now = '0;
        kind_now = KIND_SILENT;

        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= REQ_LOAD;
        req_ch.frame_low     <= '0;
        req_ch.frame_high    <= '0;
        req_ch.last_of_frame <= 1'b0;
        i_rst_n              <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_silent_start();
        test_code_ranges();
        test_vote_threshold();
        test_receiver_stall();
        test_sender_pause();
        test_random_stream();

        // let the pipe empty, then watch for stray words
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_words.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
